// File: design/snat_pkg.sv
// shared types, constants and checksum helper for the static nat block
package snat_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned OpIdxW = 6;
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    OP_PACKET     = 3'd0,
    OP_WR_EGRESS  = 3'd1,
    OP_WR_REVERSE = 3'd2,
    OP_RM_EGRESS  = 3'd3,
    OP_RM_REVERSE = 3'd4
  } op_e;

  localparam logic [1:0] VERDICT_DROP     = 2'd0;
  localparam logic [1:0] VERDICT_REDIRECT = 2'd1;
  localparam logic [1:0] VERDICT_TABLE    = 2'd2;

  localparam logic [1:0] PORT_INSIDE  = 2'd1;
  localparam logic [1:0] PORT_OUTSIDE = 2'd2;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] LEN_ETH      = 8'd14;
  localparam logic [7:0] LEN_IP       = 8'd34;
  localparam logic [7:0] LEN_SMALL_L4 = 8'd42;
  localparam logic [7:0] LEN_TCP      = 8'd54;

  // classified word handed from front to back
  typedef struct packed {
    logic            is_table;
    logic            is_bad_op;
    logic            is_arp;
    logic            lookup;      // ipv4 with protocol and length ok, port valid
    logic            use_rev;     // lookup in reverse table (from outside)
    logic            fix_l4;
    logic [1:0]      arp_port;
    logic            tab_wr;      // table op with index inside the table
    logic            tab_rev;     // table op targets the reverse table
    logic            tab_set;     // write entry, else remove it
    logic [IdxW-1:0] tab_idx;
    logic [31:0]     key;         // lookup key, or entry key for table ops
    logic [31:0]     val;         // entry value for table ops
    logic [31:0]     src;
    logic [31:0]     dst;
    logic [15:0]     ipc;
    logic [15:0]     l4c;
  } job_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [1:0]  out_port;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ipc;
    logic [15:0] l4c;
  } res_t;

  // rfc 1624 update of a checksum for a swapped 32-bit value
  function automatic logic [15:0] csum_swap32(logic [15:0] hc, logic [31:0] oldv,
                                             logic [31:0] newv);
    logic [18:0] s;
    logic [16:0] f;
    s = {3'd0, ~hc} + {3'd0, ~oldv[31:16]} + {3'd0, ~oldv[15:0]} + {3'd0, newv[31:16]}
        + {3'd0, newv[15:0]};
    f = 17'(s[15:0]) + 17'(s[18:16]);
    f = 17'(f[15:0]) + 17'(f[16]);
    return ~f[15:0];
  endfunction

endpackage

// File: design/snat_front.sv
// front end: decodes words and classifies them into jobs for the back end
module snat_front (
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [2:0]          opcode_i,
  input  logic [5:0]          table_index_i,
  input  logic [31:0]         entry_key_i,
  input  logic [31:0]         entry_value_i,
  input  logic [1:0]          in_port_i,
  input  logic [15:0]         ethertype_i,
  input  logic [7:0]          ip_protocol_i,
  input  logic [7:0]          captured_bytes_i,
  input  logic [31:0]         src_addr_i,
  input  logic [31:0]         dst_addr_i,
  input  logic [15:0]         ip_checksum_i,
  input  logic [15:0]         l4_checksum_i,
  output logic                push_o,
  output snat_pkg::job_t      job_o,
  input  logic                full_i
);
  import snat_pkg::*;

  logic acc;
  logic is_tab;
  logic need_ok;
  logic [7:0] need;

  assign ready_o = !full_i;
  assign acc = valid_i && ready_o;
  assign push_o = acc;
  assign is_tab = (opcode_i == OP_WR_EGRESS) || (opcode_i == OP_WR_REVERSE) ||
                  (opcode_i == OP_RM_EGRESS) || (opcode_i == OP_RM_REVERSE);

  always_comb begin
    case (ip_protocol_i)
      PROTO_ICMP, PROTO_UDP: need = LEN_SMALL_L4;
      PROTO_TCP: need = LEN_TCP;
      default: need = 8'd0;
    endcase
  end
  assign need_ok = (need != 8'd0) && (captured_bytes_i >= need);

  always_comb begin
    job_o = '0;
    job_o.is_table = is_tab;
    job_o.is_bad_op = (opcode_i != OP_PACKET) && !is_tab;
    job_o.tab_wr = is_tab && (32'(table_index_i) < TableEntries);
    job_o.tab_rev = (opcode_i == OP_WR_REVERSE) || (opcode_i == OP_RM_REVERSE);
    job_o.tab_set = (opcode_i == OP_WR_EGRESS) || (opcode_i == OP_WR_REVERSE);
    job_o.tab_idx = table_index_i[IdxW-1:0];
    job_o.val = entry_value_i;
    job_o.src = src_addr_i;
    job_o.dst = dst_addr_i;
    job_o.ipc = ip_checksum_i;
    job_o.l4c = l4_checksum_i;
    job_o.use_rev = (in_port_i == PORT_OUTSIDE);
    job_o.key = is_tab ? entry_key_i :
                (in_port_i == PORT_OUTSIDE) ? dst_addr_i : src_addr_i;
    job_o.fix_l4 = (ip_protocol_i != PROTO_ICMP);
    if (captured_bytes_i >= LEN_ETH) begin
      if (ethertype_i == ETH_ARP) begin
        job_o.is_arp = (in_port_i == PORT_INSIDE) || (in_port_i == PORT_OUTSIDE);
        job_o.arp_port = (in_port_i == PORT_OUTSIDE) ? PORT_INSIDE : PORT_OUTSIDE;
      end else if (ethertype_i == ETH_IPV4 && captured_bytes_i >= LEN_IP) begin
        job_o.lookup = need_ok &&
                       ((in_port_i == PORT_INSIDE) || (in_port_i == PORT_OUTSIDE));
      end
    end
  end
endmodule

// File: design/snat_queue.sv
// short fifo of classified jobs between front and back
module snat_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  snat_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output snat_pkg::job_t data_o
);
  import snat_pkg::*;

  job_t mem_q [QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'(QDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// File: design/snat_back.sv
// back end: holds both tables, matches, rewrites and registers the result
module snat_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  snat_pkg::job_t            job_i,
  output logic                      pop_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output snat_pkg::res_t            res_o
);
  import snat_pkg::*;

  // valid bits and keys in flops: each entry compared in parallel
  logic [TableEntries-1:0] eg_v_q, rv_v_q;
  logic [31:0] eg_k_q [TableEntries];
  logic [31:0] rv_k_q [TableEntries];
  // values: read once per job at the matched index
  logic [31:0] eg_x_q [TableEntries];
  logic [31:0] rv_x_q [TableEntries];

  logic tab_we;
  logic [TableEntries-1:0] hits;
  logic [IdxW-1:0] hit_idx;
  logic s1_v_q, s2_v_q, vld_q;
  job_t s1_job_q, s2_job_q;
  logic s1_hit_q, s2_hit_q;
  logic [IdxW-1:0] s1_idx_q;
  logic [31:0] s2_val_q;
  res_t res_d, res_q;

  // one job in flight: compare, value read, checksum update
  assign pop_o = job_valid_i && !s1_v_q && !s2_v_q && (!vld_q || ready_i);
  assign tab_we = pop_o && job_i.is_table && job_i.tab_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eg_v_q <= '0;
      rv_v_q <= '0;
    end else if (tab_we) begin
      if (job_i.tab_rev) rv_v_q[job_i.tab_idx] <= job_i.tab_set;
      else eg_v_q[job_i.tab_idx] <= job_i.tab_set;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we && job_i.tab_set) begin
      if (job_i.tab_rev) begin
        rv_k_q[job_i.tab_idx] <= job_i.key;
        rv_x_q[job_i.tab_idx] <= job_i.val;
      end else begin
        eg_k_q[job_i.tab_idx] <= job_i.key;
        eg_x_q[job_i.tab_idx] <= job_i.val;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hits[i] = job_i.use_rev ? (rv_v_q[i] && rv_k_q[i] == job_i.key)
                              : (eg_v_q[i] && eg_k_q[i] == job_i.key);
    end
  end

  // lowest matching index wins
  always_comb begin
    hit_idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (hits[i]) hit_idx = IdxW'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      s1_v_q <= pop_o;
      s2_v_q <= s1_v_q;
      if (s2_v_q) vld_q <= 1'b1;
      else if (ready_i) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_job_q <= job_i;
      s1_hit_q <= job_i.lookup && (hits != '0);
      s1_idx_q <= hit_idx;
    end
    if (s1_v_q) begin
      s2_job_q <= s1_job_q;
      s2_hit_q <= s1_hit_q;
      s2_val_q <= s1_job_q.use_rev ? rv_x_q[s1_idx_q] : eg_x_q[s1_idx_q];
    end
    if (s2_v_q) res_q <= res_d;
  end

  always_comb begin
    res_d = '0;
    if (s2_job_q.is_table) begin
      res_d.verdict = VERDICT_TABLE;
    end else if (!s2_job_q.is_bad_op) begin
      res_d.src = s2_job_q.src;
      res_d.dst = s2_job_q.dst;
      res_d.ipc = s2_job_q.ipc;
      res_d.l4c = s2_job_q.l4c;
      if (s2_job_q.is_arp) begin
        res_d.verdict = VERDICT_REDIRECT;
        res_d.out_port = s2_job_q.arp_port;
      end else if (s2_hit_q) begin
        res_d.verdict = VERDICT_REDIRECT;
        res_d.out_port = s2_job_q.use_rev ? PORT_INSIDE : PORT_OUTSIDE;
        if (s2_job_q.use_rev) res_d.dst = s2_val_q;
        else res_d.src = s2_val_q;
        res_d.ipc = csum_swap32(s2_job_q.ipc, s2_job_q.key, s2_val_q);
        if (s2_job_q.fix_l4) res_d.l4c = csum_swap32(s2_job_q.l4c, s2_job_q.key, s2_val_q);
      end
    end
  end

  assign valid_o = vld_q;
  assign res_o = res_q;
endmodule

// File: design/static_nat_header_rewrite.sv
// top level of the static one-to-one nat header rewrite block
// Static NAT on parsed header words. The front accepts a word whenever the
// two-entry job queue has room. The back end works on one job at a time: a
// parallel 64-entry key compare with lowest-index select, a registered read
// of the matched value, then the two checksum updates into the output
// register. A result passes the job queue, then the compare, value and output
// registers before it is offered; a new job is taken only once the last has
// reached a free output register. The input stalls once the queue is full, and
// a result held by the receiver stops the back end. Table writes and removes
// are applied when the back end takes them from the queue, so packets see
// table changes in arrival order. Each word yields exactly one result word.
module static_nat_header_rewrite (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: opcode[2:0], table_index[8:3], entry_key[40:9], entry_value[72:41],
  // in_port[74:73], ethertype[90:75], ip_protocol[98:91],
  // captured_bytes[106:99], src_addr[138:107], dst_addr[170:139],
  // ip_checksum[186:171], l4_checksum[202:187], zero fill
  input  logic [207:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: verdict[1:0], out_port[3:2], src_addr_out[35:4],
  // dst_addr_out[67:36], ip_checksum_out[83:68], l4_checksum_out[99:84], zero fill
  output logic [103:0]  m_axis_tdata
);
  import snat_pkg::*;

  logic push, full, pop, qv;
  job_t job_in, job_out;
  res_t res;

  // front: decode and classify
  snat_front u_front (
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .opcode_i(s_axis_tdata[2:0]), .table_index_i(s_axis_tdata[8:3]),
    .entry_key_i(s_axis_tdata[40:9]), .entry_value_i(s_axis_tdata[72:41]),
    .in_port_i(s_axis_tdata[74:73]), .ethertype_i(s_axis_tdata[90:75]),
    .ip_protocol_i(s_axis_tdata[98:91]), .captured_bytes_i(s_axis_tdata[106:99]),
    .src_addr_i(s_axis_tdata[138:107]), .dst_addr_i(s_axis_tdata[170:139]),
    .ip_checksum_i(s_axis_tdata[186:171]), .l4_checksum_i(s_axis_tdata[202:187]),
    .push_o(push), .job_o(job_in), .full_i(full)
  );

  // decoupling queue
  snat_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(job_in), .full_o(full),
    .pop_i(pop), .valid_o(qv), .data_o(job_out)
  );

  // back: table updates, lookup, rewrite, output register
  snat_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(qv), .job_i(job_out), .pop_o(pop),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {4'd0, res.l4c, res.ipc, res.dst, res.src, res.out_port,
                         res.verdict};

  logic unused_pad;
  assign unused_pad = ^s_axis_tdata[207:203];
endmodule

// File: verif/snat_checker.sv
// checker that predicts nat results from accepted words and compares them
module snat_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_fire_i,
  input  logic [207:0] in_data_i,
  input  logic         out_fire_i,
  input  logic [103:0] out_data_i,
  output int           fail_count_o,
  output int           pending_o
);
  import snat_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
  } slot_t;

  slot_t egress_tbl[TableEntries];
  slot_t reverse_tbl[TableEntries];
  res_t  expected_results[$];

  assign pending_o = expected_results.size();

  // ones-complement swap of a 32-bit value, written independently of the package
  function automatic logic [15:0] swap_sum(logic [15:0] hc, logic [31:0] oldv,
                                           logic [31:0] newv);
    int unsigned s;
    s = {16'd0, ~hc} + {16'd0, ~oldv[31:16]} + {16'd0, ~oldv[15:0]}
        + {16'd0, newv[31:16]} + {16'd0, newv[15:0]};
    while (s > 32'hffff) s = (s & 32'hffff) + (s >> 16);
    return ~s[15:0];
  endfunction

  function automatic bit find_slot(bit rev, logic [31:0] key, output logic [31:0] val);
    val = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (rev ? (reverse_tbl[i].valid && reverse_tbl[i].key == key)
              : (egress_tbl[i].valid && egress_tbl[i].key == key)) begin
        val = rev ? reverse_tbl[i].value : egress_tbl[i].value;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t predict_rewrite(logic [207:0] d);
    logic [2:0] op;
    logic [5:0] idx;
    logic [1:0] port;
    logic [15:0] etype;
    logic [7:0] proto, cap, need;
    logic [31:0] oldv, newv;
    bit hit;
    res_t r;
    op = d[2:0]; idx = d[8:3]; port = d[74:73]; etype = d[90:75];
    proto = d[98:91]; cap = d[106:99];
    r = '0;
    if (op inside {OP_WR_EGRESS, OP_WR_REVERSE, OP_RM_EGRESS, OP_RM_REVERSE}) begin
      if (idx < TableEntries) begin
        case (op)
          OP_WR_EGRESS:  egress_tbl[idx] = {1'b1, d[40:9], d[72:41]};
          OP_WR_REVERSE: reverse_tbl[idx] = {1'b1, d[40:9], d[72:41]};
          OP_RM_EGRESS:  egress_tbl[idx] = '0;
          default:       reverse_tbl[idx] = '0;
        endcase
      end
      r.verdict = VERDICT_TABLE;
      return r;
    end
    if (op != OP_PACKET) return r;
    r.src = d[138:107]; r.dst = d[170:139]; r.ipc = d[186:171]; r.l4c = d[202:187];
    if (cap < LEN_ETH) return r;
    if (etype == ETH_ARP) begin
      if (port == PORT_OUTSIDE || port == PORT_INSIDE) begin
        r.verdict = VERDICT_REDIRECT;
        r.out_port = (port == PORT_OUTSIDE) ? PORT_INSIDE : PORT_OUTSIDE;
      end
      return r;
    end
    if (etype != ETH_IPV4 || cap < LEN_IP) return r;
    need = (proto == PROTO_ICMP || proto == PROTO_UDP) ? LEN_SMALL_L4 :
           (proto == PROTO_TCP) ? LEN_TCP : 8'd0;
    if (need == 0 || cap < need) return r;
    hit = 0; oldv = '0; newv = '0;
    if (port == PORT_INSIDE) begin
      hit = find_slot(0, r.src, newv);
      if (hit) begin oldv = r.src; r.src = newv; r.out_port = PORT_OUTSIDE; end
    end else if (port == PORT_OUTSIDE) begin
      hit = find_slot(1, r.dst, newv);
      if (hit) begin oldv = r.dst; r.dst = newv; r.out_port = PORT_INSIDE; end
    end
    if (hit) begin
      r.verdict = VERDICT_REDIRECT;
      r.ipc = swap_sum(r.ipc, oldv, newv);
      if (proto != PROTO_ICMP) r.l4c = swap_sum(r.l4c, oldv, newv);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r, got;
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) begin
        egress_tbl[i] = '0;
        reverse_tbl[i] = '0;
      end
      expected_results.delete();
      fail_count_o <= 0;
    end else begin
      if (in_fire_i) expected_results.push_back(predict_rewrite(in_data_i));
      if (out_fire_i) begin
        got.verdict = out_data_i[1:0];
        got.out_port = out_data_i[3:2];
        got.src = out_data_i[35:4];
        got.dst = out_data_i[67:36];
        got.ipc = out_data_i[83:68];
        got.l4c = out_data_i[99:84];
        if (expected_results.size() == 0) begin
          $error("result word with no expectation: %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r || out_data_i[103:100] !== 4'd0) begin
            if (got.verdict !== exp_r.verdict)
              $error("verdict expected %0d actual %0d", exp_r.verdict, got.verdict);
            if (got.out_port !== exp_r.out_port)
              $error("out_port expected %0d actual %0d", exp_r.out_port, got.out_port);
            if (got.src !== exp_r.src)
              $error("src_addr_out expected %h actual %h", exp_r.src, got.src);
            if (got.dst !== exp_r.dst)
              $error("dst_addr_out expected %h actual %h", exp_r.dst, got.dst);
            if (got.ipc !== exp_r.ipc)
              $error("ip_checksum_out expected %h actual %h", exp_r.ipc, got.ipc);
            if (got.l4c !== exp_r.l4c)
              $error("l4_checksum_out expected %h actual %h", exp_r.l4c, got.l4c);
            if (out_data_i[103:100] !== 4'd0)
              $error("zero fill expected 0 actual %h", out_data_i[103:100]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: verif/tb_static_nat_header_rewrite.sv
// stimulus and verdict for the static nat header rewrite block
module tb_static_nat_header_rewrite;
  import snat_pkg::*;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [207:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [103:0] m_axis_tdata;
  int           fail_count, pending, idle_cycles;
  int           send_idle_pct, recv_idle_pct;
  logic [31:0]  known_keys[8];
  logic [31:0]  known_rkeys[8];

  static_nat_header_rewrite dut (.*);

  snat_checker u_checker (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready), .in_data_i(s_axis_tdata),
    .out_fire_i(m_axis_tvalid && m_axis_tready), .out_data_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no word accepted and no result taken
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [207:0] pack_word(logic [2:0] op, logic [5:0] idx,
      logic [31:0] k, logic [31:0] v, logic [1:0] port, logic [15:0] et,
      logic [7:0] pr, logic [7:0] cap, logic [31:0] s, logic [31:0] d,
      logic [15:0] ic, logic [15:0] lc);
    return {5'd0, lc, ic, d, s, cap, pr, et, port, v, k, idx, op};
  endfunction

  // tvalid stays high after acceptance until the next word or an idle cycle
  task automatic send_word(logic [207:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_packet(logic [1:0] port, logic [15:0] et, logic [7:0] pr,
      logic [7:0] cap, logic [31:0] s, logic [31:0] d);
    send_word(pack_word(OP_PACKET, 6'($urandom), $urandom, $urandom, port, et, pr, cap,
                        s, d, 16'($urandom), 16'($urandom)));
  endtask

  task automatic random_word();
    logic [7:0] pr, cap;
    logic [1:0] port;
    int k;
    k = $urandom_range(99);
    pr = ($urandom_range(9) == 0) ? 8'($urandom) :
         ($urandom_range(2) == 0 ? PROTO_ICMP : $urandom_range(1) ? PROTO_TCP : PROTO_UDP);
    cap = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(255, 54));
    port = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(2, 1));
    if (k < 12) begin
      int slot;
      slot = $urandom_range(7);
      known_keys[slot] = ($urandom_range(3) == 0) ? known_keys[$urandom_range(7)] : $urandom;
      send_word(pack_word(OP_WR_EGRESS, ($urandom_range(3) == 0) ? 6'($urandom) : 6'(slot),
                          known_keys[slot], $urandom, 0, 0, 0, 0, 0, 0, 0, 0));
    end else if (k < 24) begin
      int slot;
      slot = $urandom_range(7);
      known_rkeys[slot] = $urandom;
      send_word(pack_word(OP_WR_REVERSE, ($urandom_range(3) == 0) ? 6'($urandom) : 6'(slot),
                          known_rkeys[slot], $urandom, 0, 0, 0, 0, 0, 0, 0, 0));
    end else if (k < 28) begin
      send_word(pack_word(3'($urandom_range(4, 3)), 6'($urandom_range(15)), $urandom,
                          $urandom, 2'($urandom), 16'($urandom), 8'($urandom),
                          8'($urandom), $urandom, $urandom, 16'($urandom),
                          16'($urandom)));
    end else if (k < 30) begin
      send_word(pack_word(3'($urandom_range(7, 5)), 6'($urandom), $urandom, $urandom,
                          2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                          $urandom, $urandom, 16'($urandom), 16'($urandom)));
    end else if (k < 36) begin
      send_packet(2'($urandom), ($urandom_range(1) ? ETH_ARP : 16'($urandom)),
                  8'($urandom), 8'($urandom), $urandom, $urandom);
    end else begin
      send_packet(port, ETH_IPV4, pr, cap,
                  $urandom_range(2) ? known_keys[$urandom_range(7)] : $urandom,
                  $urandom_range(2) ? known_rkeys[$urandom_range(7)] : $urandom);
    end
  endtask

  initial begin
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    idle_cycles = 0;
    send_idle_pct = 30;
    recv_idle_pct = 78;
    for (int i = 0; i < 8; i++) begin
      known_keys[i] = $urandom;
      known_rkeys[i] = $urandom;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: table ops at extreme indexes and values, duplicate keys
    send_word(pack_word(OP_WR_EGRESS, 6'd63, 32'hffff_ffff, 32'h0, '1, '1, '1, '1, '1, '1,
                        '1, '1));
    send_word(pack_word(OP_WR_EGRESS, 6'd5, known_keys[0], 32'h0a00_0001, 0, 0, 0, 0, 0,
                        0, 0, 0));
    send_word(pack_word(OP_WR_EGRESS, 6'd0, known_keys[0], 32'hc0a8_0101, 0, 0, 0, 0, 0,
                        0, 0, 0));
    send_word(pack_word(OP_WR_REVERSE, 6'd0, known_rkeys[0], 32'hffff_ffff, 0, 0, 0, 0, 0,
                        0, 0, 0));
    send_packet(PORT_INSIDE, ETH_IPV4, PROTO_TCP, 8'd54, known_keys[0], 32'h0);
    send_packet(PORT_INSIDE, ETH_IPV4, PROTO_TCP, 8'd53, known_keys[0], 32'h0);
    send_packet(PORT_INSIDE, ETH_IPV4, PROTO_UDP, 8'd42, 32'hffff_ffff, 32'h1);
    send_word(pack_word(OP_PACKET, 0, 0, 0, PORT_OUTSIDE, ETH_IPV4, PROTO_UDP, 8'd255, 0,
                        known_rkeys[0], 16'hffff, 16'h0));
    send_packet(PORT_OUTSIDE, ETH_IPV4, PROTO_ICMP, 8'd42, 0, known_rkeys[0]);
    send_packet(PORT_OUTSIDE, ETH_IPV4, PROTO_ICMP, 8'd41, 0, known_rkeys[0]);
    send_packet(PORT_OUTSIDE, ETH_IPV4, 8'd255, 8'd255, 0, known_rkeys[0]);
    send_packet(2'd3, ETH_IPV4, PROTO_TCP, 8'd255, known_keys[0], known_rkeys[0]);
    send_packet(2'd0, ETH_IPV4, PROTO_TCP, 8'd255, known_keys[0], known_rkeys[0]);
    send_packet(PORT_INSIDE, ETH_ARP, 0, 8'd14, 0, 0);
    send_packet(PORT_OUTSIDE, ETH_ARP, 0, 8'd14, 0, 0);
    send_packet(2'd3, ETH_ARP, 0, 8'd14, 0, 0);
    send_packet(PORT_INSIDE, ETH_ARP, 0, 8'd13, 0, 0);
    send_packet(PORT_INSIDE, 16'hffff, PROTO_TCP, 8'd255, known_keys[0], 0);
    send_packet(PORT_INSIDE, ETH_IPV4, PROTO_TCP, 8'd33, known_keys[0], 0);
    send_packet(PORT_INSIDE, ETH_IPV4, PROTO_TCP, 8'd255, 32'h1234_5678, 0);
    send_word(pack_word(3'd7, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_word(pack_word(OP_RM_EGRESS, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_packet(PORT_INSIDE, ETH_IPV4, PROTO_TCP, 8'd255, known_keys[0], 0);
    send_word(pack_word(OP_RM_REVERSE, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // random phases: receiver-heavy idling, sender-heavy, then none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 30 : 0;
      for (int n = 0; n < 550; n++) random_word();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
